// ----- sv/window_pick_and_drag_controller_core_defines.svh -----
// assertion helpers for the window controller checker
`ifndef WINDOW_PICK_AND_DRAG_CONTROLLER_CORE_DEFINES_SVH
`define WINDOW_PICK_AND_DRAG_CONTROLLER_CORE_DEFINES_SVH

// same-cycle implication, sampled on the rising clock
`define WPD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/wpd_pkg.sv -----
package wpd_pkg;

    localparam int WINDOW_COUNT_DEF = 8;

    localparam int MIN_W   = 180;
    localparam int MIN_H   = 130;
    localparam int GRIP    = 14;
    localparam int DIM_MAX = 4095;
    localparam int BTN_GAP = 4;

    localparam logic [11:0] SCREEN_W_RST = 12'd1024;
    localparam logic [11:0] SCREEN_H_RST = 12'd768;
    localparam logic [7:0]  TASKBAR_RST  = 8'd40;
    localparam logic [7:0]  TITLE_RST    = 8'd32;
    localparam logic [7:0]  BTN_W_RST    = 8'd20;
    localparam logic [7:0]  BTN_H_RST    = 8'd20;
    localparam logic [7:0]  BTN_PAD_RST  = 8'd6;

    typedef logic signed [15:0] s16_t;

    typedef enum logic [2:0] {
        OP_MOUSE  = 3'd0,
        OP_SHOW   = 3'd1,
        OP_HIDE   = 3'd2,
        OP_TOGGLE = 3'd3,
        OP_PLACE  = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        REG_NONE  = 3'd0,
        REG_CLOSE = 3'd1,
        REG_MIN   = 3'd2,
        REG_MAX   = 3'd3,
        REG_GRIP  = 3'd4,
        REG_TITLE = 3'd5,
        REG_BODY  = 3'd6
    } region_t;

    typedef enum logic [2:0] {
        CFG_SCREEN_W = 3'd0,
        CFG_SCREEN_H = 3'd1,
        CFG_TASKBAR  = 3'd2,
        CFG_TITLE    = 3'd3,
        CFG_BTN_W    = 3'd4,
        CFG_BTN_H    = 3'd5,
        CFG_BTN_PAD  = 3'd6
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_DRAG,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [7:0] btn_w;
        logic [7:0] btn_h;
        logic [7:0] btn_pad;
        logic [7:0] title_h;
    } chrome_cfg_t;

endpackage

// ----- sv/wpd_cmd_if.sv -----
interface wpd_cmd_if;
    logic              valid;
    logic              ready;
    logic [2:0]        operation;
    logic signed [12:0] pointer_x;
    logic signed [12:0] pointer_y;
    logic              left_button;
    logic              prev_left_button;
    logic [2:0]        window_id;
    logic signed [12:0] place_x;
    logic signed [12:0] place_y;
    logic [11:0]       place_w;
    logic [11:0]       place_h;

    modport source (output valid, operation, pointer_x, pointer_y, left_button,
                    prev_left_button, window_id, place_x, place_y, place_w, place_h,
                    input ready);
    modport sink (input valid, operation, pointer_x, pointer_y, left_button,
                  prev_left_button, window_id, place_x, place_y, place_w, place_h,
                  output ready);
endinterface

// ----- sv/wpd_rsp_if.sv -----
interface wpd_rsp_if;
    logic              valid;
    logic              ready;
    logic              focus_valid;
    logic [2:0]        focus_id;
    logic              hit_valid;
    logic [2:0]        hit_id;
    logic [2:0]        hit_region;
    logic signed [12:0] focus_x;
    logic signed [12:0] focus_y;
    logic [11:0]       focus_w;
    logic [11:0]       focus_h;

    modport source (output valid, focus_valid, focus_id, hit_valid, hit_id, hit_region,
                    focus_x, focus_y, focus_w, focus_h, input ready);
    modport sink (input valid, focus_valid, focus_id, hit_valid, hit_id, hit_region,
                  focus_x, focus_y, focus_w, focus_h, output ready);
endinterface

// ----- sv/wpd_cfg_if.sv -----
interface wpd_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [11:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/wpd_stack_cell.sv -----
module wpd_stack_cell #(
    parameter int ID_W     = 3,
    parameter int RESET_ID = 0,
    parameter bit IS_TOP   = 1'b0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            raise_en,
    input  logic [ID_W-1:0] raise_id,
    input  logic [ID_W-1:0] above_id,
    input  logic            seen_in,
    output logic            seen_out,
    output logic [ID_W-1:0] order_id
);

    logic [ID_W-1:0] order_reg;
    logic [ID_W-1:0] order_next;

    // once the raised id has been seen at or below this slot, slots pull from above
    assign seen_out = seen_in | (order_reg == raise_id);
    assign order_id = order_reg;

    always_comb
    begin
        order_next = order_reg;
        if (raise_en)
        begin
            if (IS_TOP)
            begin
                order_next = raise_id;
            end
            else if (seen_out)
            begin
                order_next = above_id;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= ID_W'(RESET_ID);
        end
        else
        begin
            order_reg <= order_next;
        end
    end

endmodule

// ----- sv/wpd_hit_unit.sv -----
module wpd_hit_unit (
    input  logic signed [12:0]  px,
    input  logic signed [12:0]  py,
    input  logic signed [12:0]  rx,
    input  logic signed [12:0]  ry,
    input  logic [11:0]         rw,
    input  logic [11:0]         rh,
    input  logic                maximized,
    input  wpd_pkg::chrome_cfg_t chrome,
    output wpd_pkg::region_t    region
);

    wpd_pkg::s16_t mx, my, x, y, w, h, bw, bh, xe, by, bw3, bw2;
    logic over_close, hit_min, hit_max, hit_grip, hit_title, over_frame;

    function automatic logic in_box(input wpd_pkg::s16_t qx, input wpd_pkg::s16_t qy,
                                    input wpd_pkg::s16_t bx, input wpd_pkg::s16_t byy,
                                    input wpd_pkg::s16_t bww, input wpd_pkg::s16_t bhh);
        in_box = (qx >= bx) && (qx < bx + bww) && (qy >= byy) && (qy < byy + bhh);
    endfunction

    always_comb
    begin
        mx  = wpd_pkg::s16_t'(px);
        my  = wpd_pkg::s16_t'(py);
        x   = wpd_pkg::s16_t'(rx);
        y   = wpd_pkg::s16_t'(ry);
        w   = wpd_pkg::s16_t'({4'b0, rw});
        h   = wpd_pkg::s16_t'({4'b0, rh});
        bw  = wpd_pkg::s16_t'({8'b0, chrome.btn_w});
        bh  = wpd_pkg::s16_t'({8'b0, chrome.btn_h});
        xe  = x + w;
        by  = y + wpd_pkg::s16_t'({8'b0, chrome.btn_pad});
        bw2 = bw <<< 1;
        bw3 = bw2 + bw;

        over_close = in_box(mx, my, xe - bw - 16'(wpd_pkg::BTN_GAP), by, bw, bh);
        hit_min    = in_box(mx, my, xe - bw3 - 16'(3 * wpd_pkg::BTN_GAP), by, bw, bh);
        hit_max    = in_box(mx, my, xe - bw2 - 16'(2 * wpd_pkg::BTN_GAP), by, bw, bh);
        hit_grip   = !maximized && in_box(mx, my, xe - 16'(wpd_pkg::GRIP),
                                          y + h - 16'(wpd_pkg::GRIP),
                                          16'(wpd_pkg::GRIP), 16'(wpd_pkg::GRIP));
        hit_title  = in_box(mx, my, x, y, w, wpd_pkg::s16_t'({8'b0, chrome.title_h}));
        over_frame = in_box(mx, my, x, y, w, h);

        if (over_close)
            region = wpd_pkg::REG_CLOSE;
        else if (hit_min)
            region = wpd_pkg::REG_MIN;
        else if (hit_max)
            region = wpd_pkg::REG_MAX;
        else if (hit_grip)
            region = wpd_pkg::REG_GRIP;
        else if (hit_title)
            region = wpd_pkg::REG_TITLE;
        else if (over_frame)
            region = wpd_pkg::REG_BODY;
        else
            region = wpd_pkg::REG_NONE;
    end

endmodule

// ----- sv/window_pick_and_drag_controller_core.sv -----
// sequence: show, hide, toggle, place and unused codes go from EXEC to FINISH;
//   mouse items without a press edge go EXEC, DRAG, FINISH; a press scans one
//   stack slot per cycle in SCAN, then goes to FINISH on a hit or DRAG on a miss
// throughput: one item at a time; the next item is taken once the result is
//   in the output register, even while that result still waits
// reset: all windows minimized at zero geometry, stack identity, no focus,
//   registers to defaults; saved maximize geometry is not cleared
module window_pick_and_drag_controller_core #(
    parameter int WINDOW_COUNT = wpd_pkg::WINDOW_COUNT_DEF
) (
    input logic     clk,
    input logic     rst_n,
    wpd_cmd_if.sink cmd,
    wpd_rsp_if.source rsp,
    wpd_cfg_if.sink cfg
);

    localparam int ID_W = $clog2(WINDOW_COUNT);

    // configuration
    logic [11:0] sw_reg, sh_reg;
    logic [7:0]  tb_reg, th_reg, bw_reg, bh_reg, pad_reg;

    // captured item
    logic [2:0]         op_reg;
    logic signed [12:0] px_reg, py_reg, plx_reg, ply_reg;
    logic               btn_reg, prev_reg;
    logic [2:0]         wid_reg;
    logic [11:0]        plw_reg, plh_reg;

    wpd_pkg::state_t state_reg, state_next;
    logic [ID_W-1:0] idx_reg, idx_next;
    logic            hv_reg, hv_next;
    logic [2:0]      hid_reg, hid_next;
    wpd_pkg::region_t hreg_reg, hreg_next;
    logic            fv_reg, fv_next;
    logic [ID_W-1:0] fid_reg, fid_next;

    // per-window state
    logic signed [12:0] rx_reg [WINDOW_COUNT];
    logic signed [12:0] rx_next [WINDOW_COUNT];
    logic signed [12:0] ry_reg [WINDOW_COUNT];
    logic signed [12:0] ry_next [WINDOW_COUNT];
    logic [11:0] rw_reg [WINDOW_COUNT];
    logic [11:0] rw_next [WINDOW_COUNT];
    logic [11:0] rh_reg [WINDOW_COUNT];
    logic [11:0] rh_next [WINDOW_COUNT];
    logic [49:0] saved_reg [WINDOW_COUNT];
    logic [49:0] saved_next [WINDOW_COUNT];
    logic [WINDOW_COUNT-1:0] min_reg, min_next, max_reg, max_next;
    logic [WINDOW_COUNT-1:0] drag_reg, drag_next, rsz_reg, rsz_next;
    logic signed [12:0] gdx_reg [WINDOW_COUNT];
    logic signed [12:0] gdx_next [WINDOW_COUNT];
    logic signed [12:0] gdy_reg [WINDOW_COUNT];
    logic signed [12:0] gdy_next [WINDOW_COUNT];
    logic signed [12:0] ax_reg [WINDOW_COUNT];
    logic signed [12:0] ax_next [WINDOW_COUNT];
    logic signed [12:0] ay_reg [WINDOW_COUNT];
    logic signed [12:0] ay_next [WINDOW_COUNT];

    // output register
    logic               ov_reg, ov_next;
    logic               o_fv_reg;
    logic [2:0]         o_fid_reg, o_hid_reg, o_hreg_reg;
    logic               o_hv_reg;
    logic signed [12:0] o_fx_reg, o_fy_reg;
    logic [11:0]        o_fw_reg, o_fh_reg;
    logic               load_out;

    // stack chain
    logic [ID_W-1:0] order [WINDOW_COUNT];
    logic [WINDOW_COUNT:0] seen;
    logic            raise_en;
    logic [ID_W-1:0] raise_id;

    logic [ID_W-1:0] act_id, wid_id;
    logic            wid_ok;
    wpd_pkg::region_t region;
    wpd_pkg::chrome_cfg_t chrome;

    wpd_pkg::s16_t mx, my, cx, cy, cw, ch, dx, dy, dh, sw16, nw, nh;
    logic [11:0] desk_h;

    function automatic logic signed [12:0] sat13(input wpd_pkg::s16_t v);
        if (v < -16'sd4096)
            sat13 = -13'sd4096;
        else if (v > 16'sd4095)
            sat13 = 13'sd4095;
        else
            sat13 = v[12:0];
    endfunction

    function automatic logic [11:0] clamp_dim(input wpd_pkg::s16_t v, input int lo);
        if (v < 16'(lo))
            clamp_dim = 12'(lo);
        else if (v > 16'(wpd_pkg::DIM_MAX))
            clamp_dim = 12'(wpd_pkg::DIM_MAX);
        else
            clamp_dim = v[11:0];
    endfunction

    assign seen[0] = 1'b0;

    for (genvar i = 0; i < WINDOW_COUNT; i++)
    begin : g_stack
        if (i == WINDOW_COUNT - 1)
        begin : g_top
            wpd_stack_cell #(.ID_W(ID_W), .RESET_ID(i), .IS_TOP(1'b1)) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .raise_en (raise_en),
                .raise_id (raise_id),
                .above_id (raise_id),
                .seen_in  (seen[i]),
                .seen_out (seen[i+1]),
                .order_id (order[i])
            );
        end
        else
        begin : g_mid
            wpd_stack_cell #(.ID_W(ID_W), .RESET_ID(i), .IS_TOP(1'b0)) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .raise_en (raise_en),
                .raise_id (raise_id),
                .above_id (order[i+1]),
                .seen_in  (seen[i]),
                .seen_out (seen[i+1]),
                .order_id (order[i])
            );
        end
    end

    assign chrome = '{btn_w: bw_reg, btn_h: bh_reg, btn_pad: pad_reg, title_h: th_reg};

    assign wid_ok = 32'(wid_reg) < WINDOW_COUNT;
    assign wid_id = ID_W'(wid_reg);

    // single read port into the window state
    always_comb
    begin
        if (state_reg == wpd_pkg::ST_SCAN)
            act_id = order[idx_reg];
        else if (state_reg == wpd_pkg::ST_EXEC && op_reg != wpd_pkg::OP_MOUSE)
            act_id = wid_id;
        else
            act_id = fid_reg;
    end

    wpd_hit_unit u_hit (
        .px        (px_reg),
        .py        (py_reg),
        .rx        (rx_reg[act_id]),
        .ry        (ry_reg[act_id]),
        .rw        (rw_reg[act_id]),
        .rh        (rh_reg[act_id]),
        .maximized (max_reg[act_id]),
        .chrome    (chrome),
        .region    (region)
    );

    assign cmd.ready = (state_reg == wpd_pkg::ST_IDLE);
    assign cfg.ready = 1'b1;
    assign load_out  = (state_reg == wpd_pkg::ST_FINISH) && (!ov_reg || rsp.ready);

    always_comb
    begin
        mx     = wpd_pkg::s16_t'(px_reg);
        my     = wpd_pkg::s16_t'(py_reg);
        cx     = wpd_pkg::s16_t'(rx_reg[act_id]);
        cy     = wpd_pkg::s16_t'(ry_reg[act_id]);
        cw     = wpd_pkg::s16_t'({4'b0, rw_reg[act_id]});
        ch     = wpd_pkg::s16_t'({4'b0, rh_reg[act_id]});
        sw16   = wpd_pkg::s16_t'({4'b0, sw_reg});
        dh     = wpd_pkg::s16_t'({4'b0, sh_reg}) - wpd_pkg::s16_t'({8'b0, tb_reg});
        desk_h = (sh_reg > {4'b0, tb_reg}) ? (sh_reg - {4'b0, tb_reg}) : sh_reg;

        // drag: clamp to desktop left/top first, then right/bottom
        dx = mx - wpd_pkg::s16_t'(gdx_reg[act_id]);
        dy = my - wpd_pkg::s16_t'(gdy_reg[act_id]);
        if (dx < 16'sd0)
            dx = 16'sd0;
        if (dx + cw > sw16)
            dx = sw16 - cw;
        if (dy < 16'sd0)
            dy = 16'sd0;
        if (dy + ch > dh)
            dy = dh - ch;

        nw = cw + (mx - wpd_pkg::s16_t'(ax_reg[act_id]));
        nh = ch + (my - wpd_pkg::s16_t'(ay_reg[act_id]));
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        hv_next    = hv_reg;
        hid_next   = hid_reg;
        hreg_next  = hreg_reg;
        fv_next    = fv_reg;
        fid_next   = fid_reg;
        rx_next    = rx_reg;
        ry_next    = ry_reg;
        rw_next    = rw_reg;
        rh_next    = rh_reg;
        saved_next = saved_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        drag_next  = drag_reg;
        rsz_next   = rsz_reg;
        gdx_next   = gdx_reg;
        gdy_next   = gdy_reg;
        ax_next    = ax_reg;
        ay_next    = ay_reg;
        ov_next    = ov_reg;
        raise_en   = 1'b0;
        raise_id   = act_id;

        if (ov_reg && rsp.ready)
            ov_next = 1'b0;

        case (state_reg)
            wpd_pkg::ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    hv_next    = 1'b0;
                    hid_next   = 3'd0;
                    hreg_next  = wpd_pkg::REG_NONE;
                    state_next = wpd_pkg::ST_EXEC;
                end
            end
            wpd_pkg::ST_EXEC:
            begin
                state_next = wpd_pkg::ST_FINISH;
                case (op_reg)
                    wpd_pkg::OP_MOUSE:
                    begin
                        if (btn_reg && !prev_reg)
                        begin
                            idx_next   = ID_W'(WINDOW_COUNT - 1);
                            state_next = wpd_pkg::ST_SCAN;
                        end
                        else
                        begin
                            state_next = wpd_pkg::ST_DRAG;
                        end
                    end
                    wpd_pkg::OP_SHOW, wpd_pkg::OP_HIDE, wpd_pkg::OP_TOGGLE:
                    begin
                        if (wid_ok)
                        begin
                            if (op_reg == wpd_pkg::OP_SHOW ||
                                (op_reg == wpd_pkg::OP_TOGGLE && min_reg[act_id]))
                            begin
                                min_next[act_id] = 1'b0;
                                fv_next          = 1'b1;
                                fid_next         = act_id;
                                raise_en         = 1'b1;
                            end
                            else
                            begin
                                min_next[act_id] = 1'b1;
                                if (fv_reg && fid_reg == act_id)
                                    fv_next = 1'b0;
                            end
                        end
                    end
                    wpd_pkg::OP_PLACE:
                    begin
                        if (wid_ok)
                        begin
                            rx_next[act_id] = plx_reg;
                            ry_next[act_id] = ply_reg;
                            rw_next[act_id] = plw_reg;
                            rh_next[act_id] = plh_reg;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            wpd_pkg::ST_SCAN:
            begin
                if (!min_reg[act_id] && region != wpd_pkg::REG_NONE)
                begin
                    hv_next    = 1'b1;
                    hid_next   = 3'(act_id);
                    hreg_next  = region;
                    state_next = wpd_pkg::ST_FINISH;
                    if (region == wpd_pkg::REG_CLOSE || region == wpd_pkg::REG_MIN)
                    begin
                        min_next[act_id] = 1'b1;
                        if (fv_reg && fid_reg == act_id)
                            fv_next = 1'b0;
                    end
                    else
                    begin
                        fv_next  = 1'b1;
                        fid_next = act_id;
                    end
                    if (region == wpd_pkg::REG_MAX)
                    begin
                        if (!max_reg[act_id])
                        begin
                            saved_next[act_id] = {rx_reg[act_id], ry_reg[act_id],
                                                  rw_reg[act_id], rh_reg[act_id]};
                            rx_next[act_id] = 13'sd0;
                            ry_next[act_id] = 13'sd0;
                            rw_next[act_id] = sw_reg;
                            rh_next[act_id] = desk_h;
                            max_next[act_id] = 1'b1;
                        end
                        else
                        begin
                            rx_next[act_id] = saved_reg[act_id][49:37];
                            ry_next[act_id] = saved_reg[act_id][36:24];
                            rw_next[act_id] = saved_reg[act_id][23:12];
                            rh_next[act_id] = saved_reg[act_id][11:0];
                            max_next[act_id] = 1'b0;
                        end
                    end
                    if (region == wpd_pkg::REG_GRIP)
                    begin
                        rsz_next[act_id] = 1'b1;
                        ax_next[act_id]  = px_reg;
                        ay_next[act_id]  = py_reg;
                    end
                    if (region == wpd_pkg::REG_TITLE)
                    begin
                        drag_next[act_id] = 1'b1;
                        gdx_next[act_id]  = sat13(mx - cx);
                        gdy_next[act_id]  = sat13(my - cy);
                    end
                    if (region == wpd_pkg::REG_TITLE || region == wpd_pkg::REG_BODY)
                        raise_en = 1'b1;
                end
                else if (idx_reg == '0)
                begin
                    state_next = wpd_pkg::ST_DRAG;
                end
                else
                begin
                    idx_next = idx_reg - 1'b1;
                end
            end
            wpd_pkg::ST_DRAG:
            begin
                state_next = wpd_pkg::ST_FINISH;
                if (btn_reg && fv_reg && drag_reg[act_id])
                begin
                    rx_next[act_id] = sat13(dx);
                    ry_next[act_id] = sat13(dy);
                end
                if (btn_reg && fv_reg && rsz_reg[act_id])
                begin
                    rw_next[act_id] = clamp_dim(nw, wpd_pkg::MIN_W);
                    rh_next[act_id] = clamp_dim(nh, wpd_pkg::MIN_H);
                    ax_next[act_id] = px_reg;
                    ay_next[act_id] = py_reg;
                end
                // release ends every drag and resize
                if (!btn_reg && prev_reg)
                begin
                    drag_next = '0;
                    rsz_next  = '0;
                end
            end
            wpd_pkg::ST_FINISH:
            begin
                if (load_out)
                begin
                    ov_next    = 1'b1;
                    state_next = wpd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wpd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wpd_pkg::ST_IDLE;
            idx_reg   <= '0;
            hv_reg    <= 1'b0;
            hid_reg   <= 3'd0;
            hreg_reg  <= wpd_pkg::REG_NONE;
            fv_reg    <= 1'b0;
            fid_reg   <= '0;
            min_reg   <= '1;
            max_reg   <= '0;
            drag_reg  <= '0;
            rsz_reg   <= '0;
            ov_reg    <= 1'b0;
            sw_reg    <= wpd_pkg::SCREEN_W_RST;
            sh_reg    <= wpd_pkg::SCREEN_H_RST;
            tb_reg    <= wpd_pkg::TASKBAR_RST;
            th_reg    <= wpd_pkg::TITLE_RST;
            bw_reg    <= wpd_pkg::BTN_W_RST;
            bh_reg    <= wpd_pkg::BTN_H_RST;
            pad_reg   <= wpd_pkg::BTN_PAD_RST;
            for (int i = 0; i < WINDOW_COUNT; i++)
            begin
                rx_reg[i]  <= '0;
                ry_reg[i]  <= '0;
                rw_reg[i]  <= '0;
                rh_reg[i]  <= '0;
                gdx_reg[i] <= '0;
                gdy_reg[i] <= '0;
                ax_reg[i]  <= '0;
                ay_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            hv_reg    <= hv_next;
            hid_reg   <= hid_next;
            hreg_reg  <= hreg_next;
            fv_reg    <= fv_next;
            fid_reg   <= fid_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
            drag_reg  <= drag_next;
            rsz_reg   <= rsz_next;
            ov_reg    <= ov_next;
            rx_reg    <= rx_next;
            ry_reg    <= ry_next;
            rw_reg    <= rw_next;
            rh_reg    <= rh_next;
            gdx_reg   <= gdx_next;
            gdy_reg   <= gdy_next;
            ax_reg    <= ax_next;
            ay_reg    <= ay_next;
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    wpd_pkg::CFG_SCREEN_W: sw_reg  <= cfg.data;
                    wpd_pkg::CFG_SCREEN_H: sh_reg  <= cfg.data;
                    wpd_pkg::CFG_TASKBAR:  tb_reg  <= cfg.data[7:0];
                    wpd_pkg::CFG_TITLE:    th_reg  <= cfg.data[7:0];
                    wpd_pkg::CFG_BTN_W:    bw_reg  <= cfg.data[7:0];
                    wpd_pkg::CFG_BTN_H:    bh_reg  <= cfg.data[7:0];
                    wpd_pkg::CFG_BTN_PAD:  pad_reg <= cfg.data[7:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        saved_reg <= saved_next;
        if (cmd.valid && cmd.ready)
        begin
            op_reg   <= cmd.operation;
            px_reg   <= cmd.pointer_x;
            py_reg   <= cmd.pointer_y;
            btn_reg  <= cmd.left_button;
            prev_reg <= cmd.prev_left_button;
            wid_reg  <= cmd.window_id;
            plx_reg  <= cmd.place_x;
            ply_reg  <= cmd.place_y;
            plw_reg  <= cmd.place_w;
            plh_reg  <= cmd.place_h;
        end
        if (load_out)
        begin
            o_fv_reg   <= fv_reg;
            o_fid_reg  <= fv_reg ? 3'(fid_reg) : 3'd0;
            o_hv_reg   <= hv_reg;
            o_hid_reg  <= hid_reg;
            o_hreg_reg <= hreg_reg;
            o_fx_reg   <= fv_reg ? rx_reg[act_id] : 13'sd0;
            o_fy_reg   <= fv_reg ? ry_reg[act_id] : 13'sd0;
            o_fw_reg   <= fv_reg ? rw_reg[act_id] : 12'd0;
            o_fh_reg   <= fv_reg ? rh_reg[act_id] : 12'd0;
        end
    end

    assign rsp.valid       = ov_reg;
    assign rsp.focus_valid = o_fv_reg;
    assign rsp.focus_id    = o_fid_reg;
    assign rsp.hit_valid   = o_hv_reg;
    assign rsp.hit_id      = o_hid_reg;
    assign rsp.hit_region  = o_hreg_reg;
    assign rsp.focus_x     = o_fx_reg;
    assign rsp.focus_y     = o_fy_reg;
    assign rsp.focus_w     = o_fw_reg;
    assign rsp.focus_h     = o_fh_reg;

endmodule

// ----- sv/wpd_checker.sv -----
`include "window_pick_and_drag_controller_core_defines.svh"

module wpd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cmd_valid,
    input logic        cmd_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic        focus_valid,
    input logic [2:0]  focus_id,
    input logic [11:0] focus_w,
    input logic        hit_valid,
    input logic [2:0]  hit_id,
    input logic [2:0]  hit_region
);

    // a result waits until taken
    `WPD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result dropped")
    // one item in flight: busy right after a transfer in
    `WPD_ASSERT_NEXT(a_busy, cmd_valid && cmd_ready, !cmd_ready, "second item taken")
    // no focus means zeroed focus fields
    `WPD_ASSERT_NOW(a_nofocus, rsp_valid && !focus_valid,
        focus_id == 3'd0 && focus_w == 12'd0, "focus fields not cleared")
    // a hit always carries a region, a miss never does
    `WPD_ASSERT_NOW(a_hit_region, rsp_valid,
        hit_valid == (hit_region != wpd_pkg::REG_NONE) && (hit_valid || hit_id == 3'd0),
        "hit fields inconsistent")

endmodule

bind window_pick_and_drag_controller_core wpd_checker u_wpd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd.valid),
    .cmd_ready   (cmd.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .focus_valid (rsp.focus_valid),
    .focus_id    (rsp.focus_id),
    .focus_w     (rsp.focus_w),
    .hit_valid   (rsp.hit_valid),
    .hit_id      (rsp.hit_id),
    .hit_region  (rsp.hit_region)
);

// ----- tb/sv/testbench.sv -----
module testbench;

    localparam int NWIN = 8;
    localparam int RANDOM_ITEMS = 1500;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [12:0] pointer_x;
        logic signed [12:0] pointer_y;
        logic               left_button;
        logic               prev_left_button;
        logic [2:0]         window_id;
        logic signed [12:0] place_x;
        logic signed [12:0] place_y;
        logic [11:0]        place_w;
        logic [11:0]        place_h;
    } cmd_t;

    typedef struct packed {
        logic               focus_valid;
        logic [2:0]         focus_id;
        logic               hit_valid;
        logic [2:0]         hit_id;
        logic [2:0]         hit_region;
        logic signed [12:0] focus_x;
        logic signed [12:0] focus_y;
        logic [11:0]        focus_w;
        logic [11:0]        focus_h;
    } rsp_t;

    typedef struct {
        cmd_t c;
        bit   has_exp;
        rsp_t e;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    always #4 clk = ~clk;

    wpd_cmd_if cmd ();
    wpd_rsp_if rsp ();
    wpd_cfg_if cfg ();

    window_pick_and_drag_controller_core #(.WINDOW_COUNT(NWIN)) u_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd.sink),
        .rsp  (rsp.source),
        .cfg  (cfg.sink)
    );

    // desktop model
    int scr_w, scr_h, bar_h, ttl_h, btn_w, btn_h, btn_pad;
    int order[NWIN];
    int wx[NWIN], wy[NWIN], ww[NWIN], wh[NWIN];
    int svx[NWIN], svy[NWIN], svw[NWIN], svh[NWIN];
    bit mini[NWIN], maxi[NWIN], drg[NWIN], rsz[NWIN];
    int gdx[NWIN], gdy[NWIN], anx[NWIN], any_[NWIN];
    bit fv;
    int fid;
    bit saved_ok[NWIN];

    rsp_t expected_q[$];
    int errors = 0;
    int cycles = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit prev_btn = 1'b0;

    function automatic int clamp13(int v);
        return v < -4096 ? -4096 : (v > 4095 ? 4095 : v);
    endfunction

    function automatic bit in_box(int px, int py, int bx, int by, int bw, int bh);
        return px >= bx && px < bx + bw && py >= by && py < by + bh;
    endfunction

    function automatic void desk_reset();
        scr_w = 1024; scr_h = 768; bar_h = 40; ttl_h = 32;
        btn_w = 20; btn_h = 20; btn_pad = 6;
        for (int i = 0; i < NWIN; i++)
        begin
            order[i] = i;
            wx[i] = 0; wy[i] = 0; ww[i] = 0; wh[i] = 0;
            mini[i] = 1; maxi[i] = 0; drg[i] = 0; rsz[i] = 0;
            gdx[i] = 0; gdy[i] = 0; anx[i] = 0; any_[i] = 0;
            saved_ok[i] = 0;
        end
        fv = 0; fid = 0;
    endfunction

    function automatic void raise_win(int id);
        int pos;
        pos = NWIN - 1;
        for (int i = NWIN - 1; i >= 0; i--)
            if (order[i] == id) pos = i;
        for (int i = pos; i + 1 < NWIN; i++) order[i] = order[i + 1];
        order[NWIN - 1] = id;
    endfunction

    function automatic void show_win(int id);
        mini[id] = 0; fv = 1; fid = id; raise_win(id);
    endfunction

    function automatic void hide_win(int id);
        mini[id] = 1;
        if (fv && fid == id) fv = 0;
    endfunction

    function automatic wpd_pkg::region_t press_win(int id, int mx, int my);
        int x, y, w, h, by;
        x = wx[id]; y = wy[id]; w = ww[id]; h = wh[id];
        by = y + btn_pad;
        if (in_box(mx, my, x + w - btn_w - 4, by, btn_w, btn_h))
        begin
            hide_win(id); return wpd_pkg::REG_CLOSE;
        end
        if (in_box(mx, my, x + w - 3 * btn_w - 12, by, btn_w, btn_h))
        begin
            hide_win(id); return wpd_pkg::REG_MIN;
        end
        if (in_box(mx, my, x + w - 2 * btn_w - 8, by, btn_w, btn_h))
        begin
            if (!maxi[id])
            begin
                svx[id] = x; svy[id] = y; svw[id] = w; svh[id] = h;
                saved_ok[id] = 1;
                wx[id] = 0; wy[id] = 0; ww[id] = scr_w;
                wh[id] = scr_h > bar_h ? scr_h - bar_h : scr_h;
                maxi[id] = 1;
            end
            else
            begin
                wx[id] = svx[id]; wy[id] = svy[id]; ww[id] = svw[id]; wh[id] = svh[id];
                maxi[id] = 0;
            end
            fv = 1; fid = id;
            return wpd_pkg::REG_MAX;
        end
        if (!maxi[id] && in_box(mx, my, x + w - wpd_pkg::GRIP, y + h - wpd_pkg::GRIP,
                                wpd_pkg::GRIP, wpd_pkg::GRIP))
        begin
            rsz[id] = 1; anx[id] = mx; any_[id] = my;
            fv = 1; fid = id;
            return wpd_pkg::REG_GRIP;
        end
        if (in_box(mx, my, x, y, w, ttl_h))
        begin
            drg[id] = 1; gdx[id] = clamp13(mx - x); gdy[id] = clamp13(my - y);
            fv = 1; fid = id; raise_win(id);
            return wpd_pkg::REG_TITLE;
        end
        if (in_box(mx, my, x, y, w, h))
        begin
            fv = 1; fid = id; raise_win(id);
            return wpd_pkg::REG_BODY;
        end
        return wpd_pkg::REG_NONE;
    endfunction

    function automatic rsp_t predict_desktop(cmd_t c);
        rsp_t r;
        int mx, my, id, hid, x, y, dh, nw, nh;
        bit done;
        wpd_pkg::region_t rg;
        r = '0;
        id = int'(c.window_id);
        done = 0;
        case (c.operation)
            wpd_pkg::OP_MOUSE:
            begin
                mx = int'(c.pointer_x); my = int'(c.pointer_y);
                if (c.left_button && !c.prev_left_button)
                    for (int i = NWIN - 1; i >= 0 && !done; i--)
                    begin
                        hid = order[i];
                        if (!mini[hid])
                        begin
                            rg = press_win(hid, mx, my);
                            if (rg != wpd_pkg::REG_NONE)
                            begin
                                r.hit_valid = 1'b1; r.hit_id = 3'(hid);
                                r.hit_region = rg; done = 1;
                            end
                        end
                    end
                if (!done && c.left_button && fv && drg[fid])
                begin
                    x = mx - gdx[fid]; y = my - gdy[fid];
                    dh = scr_h - bar_h;
                    if (x < 0) x = 0;
                    if (x + ww[fid] > scr_w) x = scr_w - ww[fid];
                    if (y < 0) y = 0;
                    if (y + wh[fid] > dh) y = dh - wh[fid];
                    wx[fid] = clamp13(x); wy[fid] = clamp13(y);
                end
                if (!done && c.left_button && fv && rsz[fid])
                begin
                    nw = ww[fid] + (mx - anx[fid]);
                    nh = wh[fid] + (my - any_[fid]);
                    anx[fid] = mx; any_[fid] = my;
                    if (nw < wpd_pkg::MIN_W) nw = wpd_pkg::MIN_W;
                    if (nh < wpd_pkg::MIN_H) nh = wpd_pkg::MIN_H;
                    if (nw > wpd_pkg::DIM_MAX) nw = wpd_pkg::DIM_MAX;
                    if (nh > wpd_pkg::DIM_MAX) nh = wpd_pkg::DIM_MAX;
                    ww[fid] = nw; wh[fid] = nh;
                end
                if (!done && !c.left_button && c.prev_left_button)
                    for (int i = 0; i < NWIN; i++)
                    begin
                        drg[i] = 0; rsz[i] = 0;
                    end
            end
            wpd_pkg::OP_SHOW: show_win(id);
            wpd_pkg::OP_HIDE: hide_win(id);
            wpd_pkg::OP_TOGGLE:
                if (mini[id]) show_win(id);
                else hide_win(id);
            wpd_pkg::OP_PLACE:
            begin
                wx[id] = int'(c.place_x); wy[id] = int'(c.place_y);
                ww[id] = int'(c.place_w); wh[id] = int'(c.place_h);
            end
            default: ;
        endcase
        r.focus_valid = fv;
        if (fv)
        begin
            r.focus_id = 3'(fid);
            r.focus_x = 13'(wx[fid]); r.focus_y = 13'(wy[fid]);
            r.focus_w = 12'(ww[fid]); r.focus_h = 12'(wh[fid]);
        end
        return r;
    endfunction

    // a maximize restore before any save must not happen
    function automatic bit hits_unsaved_restore(cmd_t c);
        int mx, my, id, x, y, w, by;
        if (c.operation != wpd_pkg::OP_MOUSE || !(c.left_button && !c.prev_left_button))
            return 0;
        mx = int'(c.pointer_x); my = int'(c.pointer_y);
        for (int i = NWIN - 1; i >= 0; i--)
        begin
            id = order[i];
            if (!mini[id])
            begin
                x = wx[id]; y = wy[id]; w = ww[id]; by = y + btn_pad;
                if (in_box(mx, my, x + w - btn_w - 4, by, btn_w, btn_h)) return 0;
                if (in_box(mx, my, x + w - 3 * btn_w - 12, by, btn_w, btn_h)) return 0;
                if (in_box(mx, my, x + w - 2 * btn_w - 8, by, btn_w, btn_h))
                    return maxi[id] && !saved_ok[id];
                if (!maxi[id] && in_box(mx, my, x + w - wpd_pkg::GRIP,
                                        y + wh[id] - wpd_pkg::GRIP,
                                        wpd_pkg::GRIP, wpd_pkg::GRIP)) return 0;
                if (in_box(mx, my, x, y, w, wh[id])) return 0;
            end
        end
        return 0;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    endtask

    // input driving
    initial
    begin
        cmd.valid = 0; cmd.operation = '0; cmd.pointer_x = '0; cmd.pointer_y = '0;
        cmd.left_button = 0; cmd.prev_left_button = 0; cmd.window_id = '0;
        cmd.place_x = '0; cmd.place_y = '0; cmd.place_w = '0; cmd.place_h = '0;
        cfg.valid = 0; cfg.index = '0; cfg.data = '0;
        rsp.ready = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n)
            rsp.ready <= (int'($urandom_range(99)) >= recv_idle_pct);

    // result checking
    always @(posedge clk)
    begin
        rsp_t got, want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got = '{rsp.focus_valid, rsp.focus_id, rsp.hit_valid, rsp.hit_id,
                    rsp.hit_region, rsp.focus_x, rsp.focus_y, rsp.focus_w, rsp.focus_h};
            if (expected_q.size() == 0)
                report_mismatch("unexpected result", 1, 0);
            else
            begin
                want = expected_q.pop_front();
                if (got.focus_valid !== want.focus_valid)
                    report_mismatch("focus_valid", int'(got.focus_valid),
                                    int'(want.focus_valid));
                if (got.focus_id !== want.focus_id)
                    report_mismatch("focus_id", int'(got.focus_id), int'(want.focus_id));
                if (got.hit_valid !== want.hit_valid)
                    report_mismatch("hit_valid", int'(got.hit_valid), int'(want.hit_valid));
                if (got.hit_id !== want.hit_id)
                    report_mismatch("hit_id", int'(got.hit_id), int'(want.hit_id));
                if (got.hit_region !== want.hit_region)
                    report_mismatch("hit_region", int'(got.hit_region),
                                    int'(want.hit_region));
                if (got.focus_x !== want.focus_x)
                    report_mismatch("focus_x", int'(got.focus_x), int'(want.focus_x));
                if (got.focus_y !== want.focus_y)
                    report_mismatch("focus_y", int'(got.focus_y), int'(want.focus_y));
                if (got.focus_w !== want.focus_w)
                    report_mismatch("focus_w", int'(got.focus_w), int'(want.focus_w));
                if (got.focus_h !== want.focus_h)
                    report_mismatch("focus_h", int'(got.focus_h), int'(want.focus_h));
            end
        end
    end

    task automatic send_item(cmd_t c, bit has_exp, rsp_t e);
        rsp_t p;
        while (int'($urandom_range(99)) < send_idle_pct) @(posedge clk);
        if (hits_unsaved_restore(c)) c.left_button = 0;
        p = predict_desktop(c);
        if (has_exp && p !== e)
            report_mismatch("table row vs model", 0, 1);
        expected_q.push_back(p);
        cmd.valid <= 1;
        cmd.operation <= c.operation; cmd.pointer_x <= c.pointer_x;
        cmd.pointer_y <= c.pointer_y; cmd.left_button <= c.left_button;
        cmd.prev_left_button <= c.prev_left_button; cmd.window_id <= c.window_id;
        cmd.place_x <= c.place_x; cmd.place_y <= c.place_y;
        cmd.place_w <= c.place_w; cmd.place_h <= c.place_h;
        @(posedge clk);
        while (!cmd.ready) @(posedge clk);
        cmd.valid <= 0;
        @(posedge clk);
    endtask

    task automatic write_reg(wpd_pkg::cfg_idx_t idx, int val);
        cfg.valid <= 1; cfg.index <= idx; cfg.data <= val[11:0];
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        cfg.valid <= 0;
        @(posedge clk);
        case (idx)
            wpd_pkg::CFG_SCREEN_W: scr_w = val & 32'hFFF;
            wpd_pkg::CFG_SCREEN_H: scr_h = val & 32'hFFF;
            wpd_pkg::CFG_TASKBAR:  bar_h = val & 32'hFF;
            wpd_pkg::CFG_TITLE:    ttl_h = val & 32'hFF;
            wpd_pkg::CFG_BTN_W:    btn_w = val & 32'hFF;
            wpd_pkg::CFG_BTN_H:    btn_h = val & 32'hFF;
            wpd_pkg::CFG_BTN_PAD:  btn_pad = val & 32'hFF;
            default: ;
        endcase
    endtask

    task automatic drain();
        while (expected_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic cmd_t mk(wpd_pkg::op_t op, int id, int px, int py, bit b, bit pb);
        cmd_t c;
        c = '0;
        c.operation = op; c.window_id = 3'(id); c.pointer_x = 13'(px);
        c.pointer_y = 13'(py);
        c.left_button = b; c.prev_left_button = pb;
        return c;
    endfunction

    function automatic cmd_t mk_place(int id, int x, int y, int w, int h);
        cmd_t c;
        c = mk(wpd_pkg::OP_PLACE, id, 0, 0, 0, 0);
        c.place_x = 13'(x); c.place_y = 13'(y); c.place_w = 12'(w); c.place_h = 12'(h);
        return c;
    endfunction

    // random item, mostly a coherent press-hold-release around the windows
    function automatic cmd_t random_item();
        cmd_t c;
        int k, id, x, y;
        c = '0;
        c.pointer_x = 13'($urandom); c.pointer_y = 13'($urandom);
        c.window_id = 3'($urandom);
        c.place_x = 13'($urandom); c.place_y = 13'($urandom);
        c.place_w = 12'($urandom); c.place_h = 12'($urandom);
        k = int'($urandom_range(99));
        if (k < 10)
        begin
            c.operation = 3'($urandom_range(int'(wpd_pkg::OP_PLACE), int'(wpd_pkg::OP_SHOW)));
            if (k < 2) c.operation = 3'($urandom_range(7, 5));
        end
        else if (k < 16)
        begin
            c.operation = wpd_pkg::OP_PLACE;
            c.place_x = 13'(int'($urandom_range(600)) - 100);
            c.place_y = 13'(int'($urandom_range(500)) - 100);
            c.place_w = 12'($urandom_range(700, 100));
            c.place_h = 12'($urandom_range(500, 60));
        end
        else
        begin
            c.operation = wpd_pkg::OP_MOUSE;
            id = int'($urandom_range(NWIN - 1));
            x = wx[id]; y = wy[id];
            case ($urandom_range(7))
                0: begin x = x + ww[id] - btn_w - 4 + int'($urandom_range(btn_w)); end
                1: begin x = x + ww[id] - 2 * btn_w - 8 + int'($urandom_range(btn_w)); end
                2: begin x = x + ww[id] - 3 * btn_w - 12 + int'($urandom_range(btn_w)); end
                3: begin x = x + ww[id] - int'($urandom_range(16)); y = y + wh[id] - 16; end
                default: x = x + int'($urandom_range(ww[id] + 4));
            endcase
            if ($urandom_range(3) == 0) y = y + int'($urandom_range(wh[id] + 4));
            else y = y + btn_pad + int'($urandom_range(btn_h));
            if ($urandom_range(4) == 0)
            begin
                x = x + int'($urandom_range(800)) - 400;
                y = y + int'($urandom_range(800)) - 400;
            end
            c.pointer_x = 13'(clamp13(x)); c.pointer_y = 13'(clamp13(y));
            c.left_button = ($urandom_range(9) < 6);
            c.prev_left_button = ($urandom_range(9) < 8) ? prev_btn : 1'($urandom);
            if ($urandom_range(19) == 0)
            begin
                c.pointer_x = 13'($urandom); c.pointer_y = 13'($urandom);
            end
            prev_btn = c.left_button;
        end
        return c;
    endfunction

    initial
    begin
        row_t rows[$];
        row_t rw;
        rsp_t none;
        none = '0;
        desk_reset();
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed table: expected values only where they are evident
        rw.has_exp = 1; rw.e = none;
        rw.c = mk(wpd_pkg::OP_MOUSE, 0, 100, 100, 1, 0); rows.push_back(rw);
        rw.c = mk(wpd_pkg::OP_HIDE, 3, 0, 0, 0, 0); rows.push_back(rw);
        rw.c = mk(wpd_pkg::op_t'(3'd7), 0, 0, 0, 0, 0); rows.push_back(rw);
        rw.has_exp = 0;
        rw.c = mk_place(2, 100, 100, 400, 300); rows.push_back(rw);
        rw.c = mk(wpd_pkg::OP_SHOW, 2, 0, 0, 0, 0); rows.push_back(rw);
        rw.c = mk_place(5, -4096, 4095, 4095, 0); rows.push_back(rw);
        rw.c = mk_place(6, 4095, -4096, 0, 4095); rows.push_back(rw);
        rw.c = mk(wpd_pkg::OP_TOGGLE, 5, 0, 0, 0, 0); rows.push_back(rw);
        rw.c = mk(wpd_pkg::OP_TOGGLE, 5, 0, 0, 0, 0); rows.push_back(rw);
        rw.c = mk(wpd_pkg::OP_MOUSE, 0, 150, 110, 1, 0); rows.push_back(rw);
        rw.c = mk(wpd_pkg::OP_MOUSE, 0, -4096, -4096, 1, 1); rows.push_back(rw);
        rw.c = mk(wpd_pkg::OP_MOUSE, 0, 4095, 4095, 1, 1); rows.push_back(rw);
        rw.c = mk(wpd_pkg::OP_MOUSE, 0, 4095, 4095, 0, 1); rows.push_back(rw);
        rw.c = mk(wpd_pkg::OP_MOUSE, 0, 4095 - 20, 4095 - 20, 1, 0); rows.push_back(rw);
        rw.c = mk(wpd_pkg::OP_MOUSE, 0, 1000, 700, 1, 0); rows.push_back(rw);
        rw.c = mk(wpd_pkg::OP_MOUSE, 0, 1000 - 20 - 8 - 10, 100, 1, 0); rows.push_back(rw);
        rw.c = mk(wpd_pkg::OP_MOUSE, 0, 1000 - 20 - 8 - 10, 10, 1, 0); rows.push_back(rw);
        rw.c = mk(wpd_pkg::OP_MOUSE, 0, 1004 - 20 - 4 + 5, 10, 1, 0); rows.push_back(rw);
        rw.c = mk(wpd_pkg::OP_SHOW, 2, 0, 0, 0, 0); rows.push_back(rw);
        rw.c = mk(wpd_pkg::OP_MOUSE, 0, 4095 - 64 + 3, 4095 - 4095 + 10, 1, 0);
        rows.push_back(rw);
        rw.c = mk(wpd_pkg::OP_MOUSE, 0, 160, 160, 1, 0); rows.push_back(rw);
        rw.c = mk(wpd_pkg::OP_MOUSE, 0, 160, 160, 0, 1); rows.push_back(rw);
        rw.c = mk(wpd_pkg::OP_HIDE, 2, 0, 0, 0, 0); rows.push_back(rw);
        foreach (rows[i]) send_item(rows[i].c, rows[i].has_exp, rows[i].e);
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                1:
                begin
                    write_reg(wpd_pkg::CFG_SCREEN_W, 4095);
                    write_reg(wpd_pkg::CFG_SCREEN_H, 4095);
                    write_reg(wpd_pkg::CFG_TASKBAR, 255); write_reg(wpd_pkg::CFG_TITLE, 255);
                    write_reg(wpd_pkg::CFG_BTN_W, 255); write_reg(wpd_pkg::CFG_BTN_H, 255);
                    write_reg(wpd_pkg::CFG_BTN_PAD, 255);
                end
                2:
                begin
                    write_reg(wpd_pkg::CFG_SCREEN_W, 1); write_reg(wpd_pkg::CFG_SCREEN_H, 1);
                    write_reg(wpd_pkg::CFG_TASKBAR, 0); write_reg(wpd_pkg::CFG_TITLE, 1);
                    write_reg(wpd_pkg::CFG_BTN_W, 1); write_reg(wpd_pkg::CFG_BTN_H, 1);
                    write_reg(wpd_pkg::CFG_BTN_PAD, 0);
                end
                3:
                begin
                    write_reg(wpd_pkg::CFG_SCREEN_W, 800); write_reg(wpd_pkg::CFG_SCREEN_H, 30);
                    write_reg(wpd_pkg::CFG_TASKBAR, 200); write_reg(wpd_pkg::CFG_TITLE, 24);
                    write_reg(wpd_pkg::CFG_BTN_W, 16); write_reg(wpd_pkg::CFG_BTN_H, 16);
                    write_reg(wpd_pkg::CFG_BTN_PAD, 4);
                end
                4:
                begin
                    write_reg(wpd_pkg::CFG_SCREEN_W, int'($urandom_range(4095, 1)));
                    write_reg(wpd_pkg::CFG_SCREEN_H, int'($urandom_range(4095, 1)));
                    write_reg(wpd_pkg::CFG_TASKBAR, int'($urandom_range(255)));
                    write_reg(wpd_pkg::CFG_TITLE, int'($urandom_range(255, 1)));
                end
                5:
                begin
                    write_reg(wpd_pkg::CFG_SCREEN_W, 1024);
                    write_reg(wpd_pkg::CFG_SCREEN_H, 768);
                    write_reg(wpd_pkg::CFG_TASKBAR, 40); write_reg(wpd_pkg::CFG_TITLE, 32);
                    write_reg(wpd_pkg::CFG_BTN_W, 20); write_reg(wpd_pkg::CFG_BTN_H, 20);
                    write_reg(wpd_pkg::CFG_BTN_PAD, 6);
                end
                default: ;
            endcase
            for (int n = 0; n < RANDOM_ITEMS / 6; n++)
            begin
                if (n == 0) begin send_idle_pct = 38; recv_idle_pct = 82; end
                if (n == RANDOM_ITEMS / 18) begin send_idle_pct = 82; recv_idle_pct = 38; end
                if (n == 2 * RANDOM_ITEMS / 18) begin send_idle_pct = 0; recv_idle_pct = 0; end
                send_item(random_item(), 0, none);
            end
            drain();
        end

        if (errors == 0 && expected_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+sv
sv/wpd_pkg.sv
sv/wpd_cmd_if.sv
sv/wpd_rsp_if.sv
sv/wpd_cfg_if.sv
sv/wpd_stack_cell.sv
sv/wpd_hit_unit.sv
sv/window_pick_and_drag_controller_core.sv
sv/wpd_checker.sv
tb/sv/testbench.sv
